[hdl/assert_macros.svh]
// assertion macros shared by the timer table rtl
// depends on i_clk and i_rst_n being visible where the macros are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define OTT_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("timer table check failed");

// next-cycle implication, checked out of reset
`define OTT_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("timer table check failed");

`endif

[hdl/ott_pkg.sv]
// shared types and codes of the ordered timer table
// no dependencies
package ott_pkg;

    localparam int OPC_W    = 3;
    localparam int SLOT_W   = 4;
    localparam int TIME_W   = 64;
    localparam int STATUS_W = 2;

    typedef logic [OPC_W-1:0]    t_opcode;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_opcode OP_ADD     = 3'd0;
    localparam t_opcode OP_CANCEL  = 3'd1;
    localparam t_opcode OP_REFRESH = 3'd2;
    localparam t_opcode OP_RESET   = 3'd3;
    localparam t_opcode OP_SCAN    = 3'd4;
    localparam t_opcode OP_QUERY   = 3'd5;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_INACTIVE = 2'd1;
    localparam t_status ST_FULL     = 2'd2;

    // most expired slots reported by one scan
    localparam int SCAN_LIMIT = 16;

    localparam t_time NO_TIMER = '1;

endpackage

[hdl/ott_ifs.sv]
// request and result channels of the ordered timer table
// depends on ott_pkg
interface ott_cmd_if;
    import ott_pkg::*;
    logic    valid;
    logic    ready;
    t_opcode opcode;
    t_slot   slot;
    t_time   period;
    logic    recurring;
    logic    restart;
    t_time   now;

    modport source (output valid, opcode, slot, period, recurring, restart, now,
                    input ready);
    modport sink   (input valid, opcode, slot, period, recurring, restart, now,
                    output ready);
endinterface

interface ott_res_if;
    import ott_pkg::*;
    logic    valid;
    logic    ready;
    t_status status;
    t_slot   timer_slot;
    logic    slot_valid;
    t_time   next_delay;
    logic    any_active;
    logic    notify_front;
    logic    last;

    modport source (output valid, status, timer_slot, slot_valid, next_delay, any_active,
                    notify_front, last, input ready);
    modport sink   (input valid, status, timer_slot, slot_valid, next_delay, any_active,
                    notify_front, last, output ready);
endinterface

[hdl/ott_ram.sv]
// single-port-write, single-port-read ram with registered read data
// no dependencies
module ott_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/ordered_timer_table.sv]
// ordered timer table: top level, sequencer around the expiry and period rams
// depends on ott_pkg, ott_ifs, ott_ram and assert_macros.svh
//
//  channel  | dir | handshake     | payload
//  i_cmd    | in  | valid / ready | opcode, slot, period, recurring, restart, now
//  o_res    | out | valid / ready | status, timer_slot, slot_valid, next_delay,
//           |     |               | any_active, notify_front, last
//
// one request at a time; cancel and unused codes go from decode to the result, refresh
// reads the slot entry first; add with a free slot and query walk the expiry ram once,
// reset reads the entry and writes the new expiry before its walk; a scan walks the
// expiry ram once per expired slot found plus a closing empty walk unless the list
// fills, at most 16 walks, then re-arms each slot (period read, then write back or free)
// and emits one result per slot; the shared ram read address serialises all these steps
// synchronous active-low reset clears the marks, the front latch and the output
// valid; a full result register holds the sequencer, and no request is taken until idle
`include "assert_macros.svh"

module ordered_timer_table #(
    parameter int NUM_TIMERS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ott_cmd_if.sink   i_cmd,
    ott_res_if.source o_res
);
    import ott_pkg::*;

    localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int LW = $clog2(SCAN_LIMIT);
    localparam int KW = LW + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;  // waiting for a request
    localparam logic [3:0] S_DEC  = 4'd1;  // decode, add and cancel done here
    localparam logic [3:0] S_RD   = 4'd2;  // slot entry read back for refresh or reset
    localparam logic [3:0] S_RST2 = 4'd3;  // reset: new expiry written
    localparam logic [3:0] S_WALK = 4'd4;  // one sweep over the expiry ram
    localparam logic [3:0] S_RA   = 4'd5;  // re-arm: read period of a fired slot
    localparam logic [3:0] S_RB   = 4'd6;  // re-arm: write back or free the slot
    localparam logic [3:0] S_EMIT = 4'd7;  // scan results out
    localparam logic [3:0] S_RESP = 4'd8;  // single result out

    logic [3:0]            r_state, n_state;

    // captured request
    t_opcode               r_op;
    t_slot                 r_slot;
    t_time                 r_per;
    logic                  r_rec_in;
    logic                  r_fnow;
    t_time                 r_now;

    // per-slot marks and the front latch
    logic [NUM_TIMERS-1:0] r_active, n_active;
    logic [NUM_TIMERS-1:0] r_recm, n_recm;
    logic                  r_front, n_front;

    // scan bookkeeping
    logic [NUM_TIMERS-1:0] r_taken, n_taken;
    logic [SW-1:0]         r_list [SCAN_LIMIT];
    logic [SW-1:0]         n_list [SCAN_LIMIT];
    logic [KW-1:0]         r_cnt, n_cnt;
    logic [KW-1:0]         r_k, n_k;

    // target slot and its new expiry (also holds the reset start time)
    logic [SW-1:0]         r_tgt, n_tgt;
    t_time                 r_e, n_e;

    // ram sweep
    logic [CW-1:0]         r_widx, n_widx;
    logic                  r_pv, n_pv;
    logic [SW-1:0]         r_pidx, n_pidx;
    logic                  r_hit, n_hit;
    logic                  r_found, n_found;
    t_time                 r_best_exp, n_best_exp;
    logic [SW-1:0]         r_best_idx, n_best_idx;

    // pending single result
    t_status               r_rs_status, n_rs_status;
    t_slot                 r_rs_slot, n_rs_slot;
    logic                  r_rs_valid, n_rs_valid;
    t_time                 r_rs_delay, n_rs_delay;
    logic                  r_rs_notify, n_rs_notify;

    // output stage
    logic                  r_ov, n_ov;
    t_status               r_o_status, n_o_status;
    t_slot                 r_o_slot, n_o_slot;
    logic                  r_o_valid, n_o_valid;
    t_time                 r_o_delay, n_o_delay;
    logic                  r_o_any, n_o_any;
    logic                  r_o_notify, n_o_notify;
    logic                  r_o_last, n_o_last;

    // ram ports
    logic                  s_exp_we, s_per_we;
    logic [SW-1:0]         s_exp_wa, s_per_wa, s_raddr;
    t_time                 s_exp_wd, s_per_wd;
    t_time                 s_exp_rd, s_per_rd;

    // helpers
    logic [SW-1:0]         s_sidx;
    logic                  s_in_range;
    logic [SW-1:0]         s_free;
    logic                  s_free_ok;
    logic                  s_out_free;
    logic                  s_act, s_block, s_cand, s_walk_last;
    logic                  s_hit_n, s_found_n;
    t_time                 s_bexp_n;
    logic [SW-1:0]         s_bidx_n;
    logic [TIME_W:0]       s_diff;
    logic [SW-1:0]         s_lk;
    logic [KW-1:0]         s_cnt_n;

    ott_ram #(.DEPTH(NUM_TIMERS), .WIDTH(TIME_W), .AW(SW)) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (s_exp_we),
        .i_waddr (s_exp_wa),
        .i_wdata (s_exp_wd),
        .i_raddr (s_raddr),
        .o_rdata (s_exp_rd)
    );

    ott_ram #(.DEPTH(NUM_TIMERS), .WIDTH(TIME_W), .AW(SW)) u_per_ram (
        .i_clk   (i_clk),
        .i_we    (s_per_we),
        .i_waddr (s_per_wa),
        .i_wdata (s_per_wd),
        .i_raddr (s_raddr),
        .o_rdata (s_per_rd)
    );

    assign s_sidx     = SW'(r_slot);
    assign s_in_range = 32'(r_slot) < NUM_TIMERS;
    assign s_out_free = !r_ov || o_res.ready;
    assign s_lk       = r_list[r_k[LW-1:0]];

    // lowest free slot
    always_comb begin
        s_free    = '0;
        s_free_ok = 1'b0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                s_free    = SW'(i);
                s_free_ok = 1'b1;
            end
        end
    end

    // one element of the sweep: data for slot r_pidx arrives this cycle
    always_comb begin
        s_act  = r_pv && r_active[r_pidx];
        // another active slot that fires before the target, a tie going to the lower slot index
        s_block = s_act && (r_pidx != r_tgt)
               && ((s_exp_rd < r_e) || ((s_exp_rd == r_e) && (r_pidx < r_tgt)));
        // earliest active slot; for a scan only untaken expired ones count
        s_cand = s_act
              && ((r_op == OP_QUERY) || (!r_taken[r_pidx] && (s_exp_rd <= r_now)))
              && (!r_found || (s_exp_rd < r_best_exp));
        s_hit_n     = r_hit | s_block;
        s_found_n   = r_found | s_cand;
        s_bexp_n    = s_cand ? s_exp_rd : r_best_exp;
        s_bidx_n    = s_cand ? r_pidx : r_best_idx;
        s_walk_last = r_pv && (r_pidx == SW'(NUM_TIMERS - 1));
        s_diff      = {1'b0, s_bexp_n} - {1'b0, r_now};
        s_cnt_n     = r_cnt + KW'(s_found_n);
    end

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_recm      = r_recm;
        n_front     = r_front;
        n_taken     = r_taken;
        n_list      = r_list;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_tgt       = r_tgt;
        n_e         = r_e;
        n_widx      = r_widx;
        n_pv        = r_pv;
        n_pidx      = r_pidx;
        n_hit       = r_hit;
        n_found     = r_found;
        n_best_exp  = r_best_exp;
        n_best_idx  = r_best_idx;
        n_rs_status = r_rs_status;
        n_rs_slot   = r_rs_slot;
        n_rs_valid  = r_rs_valid;
        n_rs_delay  = r_rs_delay;
        n_rs_notify = r_rs_notify;
        n_ov        = r_ov && !o_res.ready;
        n_o_status  = r_o_status;
        n_o_slot    = r_o_slot;
        n_o_valid   = r_o_valid;
        n_o_delay   = r_o_delay;
        n_o_any     = r_o_any;
        n_o_notify  = r_o_notify;
        n_o_last    = r_o_last;
        s_exp_we    = 1'b0;
        s_exp_wa    = r_tgt;
        s_exp_wd    = r_e;
        s_per_we    = 1'b0;
        s_per_wa    = r_tgt;
        s_per_wd    = r_per;
        s_raddr     = s_sidx;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = S_DEC;
                end
            end

            S_DEC: begin
                n_rs_status = ST_OK;
                n_rs_slot   = '0;
                n_rs_valid  = 1'b0;
                n_rs_delay  = '0;
                n_rs_notify = 1'b0;
                n_state     = S_RESP;
                case (r_op)
                    OP_ADD: begin
                        if (!s_free_ok) begin
                            n_rs_status = ST_FULL;
                        end else begin
                            s_exp_we         = 1'b1;
                            s_exp_wa         = s_free;
                            s_exp_wd         = r_now + r_per;
                            s_per_we         = 1'b1;
                            s_per_wa         = s_free;
                            s_per_wd         = r_per;
                            n_recm[s_free]   = r_rec_in;
                            n_active[s_free] = 1'b1;
                            n_tgt            = s_free;
                            n_e              = r_now + r_per;
                            n_widx           = '0;
                            n_pv             = 1'b0;
                            n_hit            = 1'b0;
                            n_found          = 1'b0;
                            n_state          = S_WALK;
                        end
                    end
                    OP_CANCEL: begin
                        if (s_in_range && r_active[s_sidx]) begin
                            n_active[s_sidx] = 1'b0;
                        end else begin
                            n_rs_status = ST_INACTIVE;
                        end
                    end
                    OP_REFRESH, OP_RESET: begin
                        if (s_in_range) begin
                            n_state = S_RD;
                        end else begin
                            n_rs_status = ST_INACTIVE;
                        end
                    end
                    OP_SCAN: begin
                        n_taken = '0;
                        n_cnt   = '0;
                        n_widx  = '0;
                        n_pv    = 1'b0;
                        n_hit   = 1'b0;
                        n_found = 1'b0;
                        n_state = S_WALK;
                    end
                    OP_QUERY: begin
                        n_front = 1'b0;
                        n_widx  = '0;
                        n_pv    = 1'b0;
                        n_hit   = 1'b0;
                        n_found = 1'b0;
                        n_state = S_WALK;
                    end
                    default: begin
                        n_rs_status = ST_OK;
                    end
                endcase
            end

            S_RD: begin
                n_state = S_RESP;
                if (r_op == OP_REFRESH) begin
                    if (r_active[s_sidx]) begin
                        s_exp_we = 1'b1;
                        s_exp_wa = s_sidx;
                        s_exp_wd = r_now + s_per_rd;
                    end else begin
                        n_rs_status = ST_INACTIVE;
                    end
                end else if (!r_fnow && (r_per == s_per_rd)) begin
                    // same period, original start kept: nothing changes
                    n_rs_status = ST_OK;
                end else if (!r_active[s_sidx]) begin
                    n_rs_status = ST_INACTIVE;
                end else begin
                    n_e     = r_fnow ? r_now : (s_exp_rd - s_per_rd);
                    n_tgt   = s_sidx;
                    n_state = S_RST2;
                end
            end

            S_RST2: begin
                s_exp_we = 1'b1;
                s_exp_wd = r_e + r_per;
                s_per_we = 1'b1;
                n_e      = r_e + r_per;
                n_widx   = '0;
                n_pv     = 1'b0;
                n_hit    = 1'b0;
                n_found  = 1'b0;
                n_state  = S_WALK;
            end

            S_WALK: begin
                if (r_widx < CW'(NUM_TIMERS)) begin
                    s_raddr = r_widx[SW-1:0];
                    n_widx  = r_widx + CW'(1);
                    n_pv    = 1'b1;
                    n_pidx  = r_widx[SW-1:0];
                end else begin
                    n_pv = 1'b0;
                end
                n_hit      = s_hit_n;
                n_found    = s_found_n;
                n_best_exp = s_bexp_n;
                n_best_idx = s_bidx_n;
                if (s_walk_last) begin
                    case (r_op)
                        OP_ADD, OP_RESET: begin
                            // new earliest timer raises notify once per latch
                            n_rs_notify = !s_hit_n && !r_front;
                            if (!s_hit_n) begin
                                n_front = 1'b1;
                            end
                            n_rs_status = ST_OK;
                            n_rs_slot   = (r_op == OP_ADD) ? SLOT_W'(r_tgt) : '0;
                            n_rs_valid  = (r_op == OP_ADD);
                            n_state     = S_RESP;
                        end
                        OP_QUERY: begin
                            if (!s_found_n) begin
                                n_rs_delay = NO_TIMER;
                            end else if (s_diff[TIME_W] || (s_diff == '0)) begin
                                n_rs_delay = '0;
                            end else begin
                                n_rs_delay = s_diff[TIME_W-1:0];
                            end
                            n_state = S_RESP;
                        end
                        default: begin
                            // one expired slot picked per sweep, in expiry order
                            n_widx  = '0;
                            n_pv    = 1'b0;
                            n_hit   = 1'b0;
                            n_found = 1'b0;
                            if (s_found_n) begin
                                n_taken[s_bidx_n]       = 1'b1;
                                n_list[r_cnt[LW-1:0]]   = s_bidx_n;
                                n_cnt                   = s_cnt_n;
                            end
                            if (!s_found_n || (r_cnt == KW'(SCAN_LIMIT - 1))) begin
                                n_k     = '0;
                                n_state = (s_cnt_n == '0) ? S_EMIT : S_RA;
                            end
                        end
                    endcase
                end
            end

            S_RA: begin
                s_raddr = s_lk;
                n_state = S_RB;
            end

            S_RB: begin
                if (r_recm[s_lk]) begin
                    s_exp_we = 1'b1;
                    s_exp_wa = s_lk;
                    s_exp_wd = r_now + s_per_rd;
                end else begin
                    n_active[s_lk] = 1'b0;
                end
                if (r_k + KW'(1) == r_cnt) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_k     = r_k + KW'(1);
                    n_state = S_RA;
                end
            end

            S_EMIT: begin
                if (s_out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = ST_OK;
                    n_o_delay  = '0;
                    n_o_any    = |r_active;
                    n_o_notify = 1'b0;
                    if (r_cnt == '0) begin
                        n_o_slot  = '0;
                        n_o_valid = 1'b0;
                        n_o_last  = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        n_o_slot  = SLOT_W'(s_lk);
                        n_o_valid = 1'b1;
                        n_o_last  = (r_k + KW'(1) == r_cnt);
                        n_k       = r_k + KW'(1);
                        if (r_k + KW'(1) == r_cnt) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            S_RESP: begin
                if (s_out_free) begin
                    n_ov       = 1'b1;
                    n_o_status = r_rs_status;
                    n_o_slot   = r_rs_slot;
                    n_o_valid  = r_rs_valid;
                    n_o_delay  = r_rs_delay;
                    n_o_any    = |r_active;
                    n_o_notify = r_rs_notify;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_recm   <= '0;
            r_front  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_recm   <= n_recm;
            r_front  <= n_front;
            r_ov     <= n_ov;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd.valid) begin
            r_op     <= i_cmd.opcode;
            r_slot   <= i_cmd.slot;
            r_per    <= i_cmd.period;
            r_rec_in <= i_cmd.recurring;
            r_fnow   <= i_cmd.restart;
            r_now    <= i_cmd.now;
        end
        r_taken     <= n_taken;
        r_list      <= n_list;
        r_cnt       <= n_cnt;
        r_k         <= n_k;
        r_tgt       <= n_tgt;
        r_e         <= n_e;
        r_widx      <= n_widx;
        r_pv        <= n_pv;
        r_pidx      <= n_pidx;
        r_hit       <= n_hit;
        r_found     <= n_found;
        r_best_exp  <= n_best_exp;
        r_best_idx  <= n_best_idx;
        r_rs_status <= n_rs_status;
        r_rs_slot   <= n_rs_slot;
        r_rs_valid  <= n_rs_valid;
        r_rs_delay  <= n_rs_delay;
        r_rs_notify <= n_rs_notify;
        r_o_status  <= n_o_status;
        r_o_slot    <= n_o_slot;
        r_o_valid   <= n_o_valid;
        r_o_delay   <= n_o_delay;
        r_o_any     <= n_o_any;
        r_o_notify  <= n_o_notify;
        r_o_last    <= n_o_last;
    end

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_ov;
    assign o_res.status       = r_o_status;
    assign o_res.timer_slot   = r_o_slot;
    assign o_res.slot_valid   = r_o_valid;
    assign o_res.next_delay   = r_o_delay;
    assign o_res.any_active   = r_o_any;
    assign o_res.notify_front = r_o_notify;
    assign o_res.last         = r_o_last;

    // a query always leaves the front latch clear
    `OTT_ASSERT_NXT(a_query_clears_front, (r_state == S_DEC) && (r_op == OP_QUERY), !r_front)
    // a scan sweep never starts with the result list already full
    `OTT_ASSERT_IMP(a_scan_list_bound, (r_state == S_WALK) && (r_op == OP_SCAN), r_cnt < KW'(SCAN_LIMIT))
    // every reported slot was picked by this scan
    `OTT_ASSERT_IMP(a_emit_taken, (r_state == S_EMIT) && (r_cnt != '0), r_taken[s_lk])

endmodule

[bench/tb_ordered_timer_table.sv]
// testbench of the ordered timer table: directed and random requests, checked
// against an in-bench model of the slot table; depends on ott_pkg and ott_ifs
module tb_ordered_timer_table;
    import ott_pkg::*;

    localparam int NT       = 16;
    localparam int N_RANDOM = 430;

    typedef struct packed {
        t_opcode opcode;
        t_slot   slot;
        t_time   period;
        logic    recurring;
        logic    restart;
        t_time   now;
    } t_req;

    typedef struct packed {
        t_status status;
        t_slot   timer_slot;
        logic    slot_valid;
        t_time   next_delay;
        logic    any_active;
        logic    notify_front;
        logic    last;
    } t_res;

    logic i_clk;
    logic i_rst_n;

    ott_cmd_if cmd_bus ();
    ott_res_if res_bus ();

    ordered_timer_table #(.NUM_TIMERS(NT)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus.sink),
        .o_res   (res_bus.source)
    );

    // model state of the slot table
    t_time exp_t  [NT];
    t_time per_t  [NT];
    logic  rec_m  [NT];
    logic  act_m  [NT];
    logic  latch;
    t_time clock_ms;

    t_req req_q[$];
    t_res due_q[$];
    int   n_err;
    int   n_res;
    int   n_req;
    bit   feed_done;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    task automatic report(input string what, input t_res got, input t_res want);
        n_err++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task automatic queue_res(input t_res r);
        due_q.insert(due_q.size(), r);
    endtask

    task automatic queue_req(input t_req q);
        req_q.insert(req_q.size(), q);
    endtask

    function automatic bit earlier(input int a, input int b);
        if (exp_t[a] != exp_t[b]) return exp_t[a] < exp_t[b];
        return a < b;
    endfunction

    function automatic logic any_act();
        for (int i = 0; i < NT; i++) if (act_m[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic front_check(input int s);
        for (int j = 0; j < NT; j++)
            if (j != s && act_m[j] && !earlier(s, j)) return 1'b0;
        if (latch) return 1'b0;
        latch = 1'b1;
        return 1'b1;
    endfunction

    function automatic t_res mk(input t_status st, input int ts, input logic sv,
                                input t_time dl, input logic nf, input logic lst);
        t_res r;
        r.status       = st;
        r.timer_slot   = t_slot'(ts);
        r.slot_valid   = sv;
        r.next_delay   = dl;
        r.any_active   = any_act();
        r.notify_front = nf;
        r.last         = lst;
        return r;
    endfunction

    // work out the results of one accepted request and apply it to the table
    task automatic predict_timers(input t_req q);
        int   s;
        int   i;
        int   best;
        int   cnt;
        int   list[$];
        bit   taken[NT];
        t_time start;
        logic  nf;
        s = q.slot;
        case (q.opcode)
            OP_ADD: begin
                for (i = 0; i < NT; i++) if (!act_m[i]) break;
                if (i >= NT) queue_res(mk(ST_FULL, 0, 0, 0, 0, 1));
                else begin
                    exp_t[i] = q.now + q.period;
                    per_t[i] = q.period;
                    rec_m[i] = q.recurring;
                    act_m[i] = 1;
                    nf = front_check(i);
                    queue_res(mk(ST_OK, i, 1, 0, nf, 1));
                end
            end
            OP_CANCEL, OP_REFRESH: begin
                if (!act_m[s]) queue_res(mk(ST_INACTIVE, 0, 0, 0, 0, 1));
                else begin
                    if (q.opcode == OP_CANCEL) act_m[s] = 0;
                    else exp_t[s] = q.now + per_t[s];
                    queue_res(mk(ST_OK, 0, 0, 0, 0, 1));
                end
            end
            OP_RESET: begin
                if (!q.restart && q.period == per_t[s])
                    queue_res(mk(ST_OK, 0, 0, 0, 0, 1));
                else if (!act_m[s]) queue_res(mk(ST_INACTIVE, 0, 0, 0, 0, 1));
                else begin
                    start = q.restart ? q.now : exp_t[s] - per_t[s];
                    per_t[s] = q.period;
                    exp_t[s] = start + q.period;
                    nf = front_check(s);
                    queue_res(mk(ST_OK, 0, 0, 0, nf, 1));
                end
            end
            OP_SCAN: begin
                for (i = 0; i < NT; i++) taken[i] = 0;
                while (list.size() < SCAN_LIMIT) begin
                    best = NT;
                    for (i = 0; i < NT; i++) begin
                        if (!act_m[i] || taken[i] || exp_t[i] > q.now) continue;
                        if (best == NT || earlier(i, best)) best = i;
                    end
                    if (best == NT) break;
                    taken[best] = 1;
                    list.insert(list.size(), best);
                end
                foreach (list[k]) begin
                    if (rec_m[list[k]]) exp_t[list[k]] = q.now + per_t[list[k]];
                    else act_m[list[k]] = 0;
                end
                cnt = list.size();
                if (cnt == 0) queue_res(mk(ST_OK, 0, 0, 0, 0, 1));
                foreach (list[k]) queue_res(mk(ST_OK, list[k], 1, 0, 0, k == cnt - 1));
            end
            OP_QUERY: begin
                latch = 0;
                best = NT;
                for (i = 0; i < NT; i++)
                    if (act_m[i] && (best == NT || earlier(i, best))) best = i;
                if (best == NT) start = NO_TIMER;
                else if (q.now >= exp_t[best]) start = '0;
                else start = exp_t[best] - q.now;
                queue_res(mk(ST_OK, 0, 0, start, 0, 1));
            end
            default: queue_res(mk(ST_OK, 0, 0, 0, 0, 1));
        endcase
    endtask

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_time rnd64();
        return {$urandom, $urandom};
    endfunction

    // small periods keep expiries near the running clock so scans find work
    function automatic t_req rnd_req();
        t_req q;
        int   r;
        q.slot      = t_slot'($urandom_range(0, 15));
        q.recurring = 1'($urandom_range(0, 1));
        q.restart   = 1'($urandom_range(0, 1));
        clock_ms    = clock_ms + 64'($urandom_range(0, 40));
        q.now       = clock_ms;
        r = $urandom_range(0, 99);
        q.period = (r < 90) ? t_time'($urandom_range(0, 120)) : rnd64();
        if ($urandom_range(0, 49) == 0) q.now = rnd64();
        r = $urandom_range(0, 99);
        if (r < 30)      q.opcode = OP_ADD;
        else if (r < 42) q.opcode = OP_CANCEL;
        else if (r < 52) q.opcode = OP_REFRESH;
        else if (r < 64) q.opcode = OP_RESET;
        else if (r < 84) q.opcode = OP_SCAN;
        else if (r < 96) q.opcode = OP_QUERY;
        else             q.opcode = t_opcode'($urandom_range(6, 7));
        return q;
    endfunction

    function automatic t_req dir(input t_opcode op, input int s, input t_time p,
                                 input logic rc, input logic fn, input t_time nw);
        t_req q;
        q.opcode = op; q.slot = t_slot'(s); q.period = p;
        q.recurring = rc; q.restart = fn; q.now = nw;
        return q;
    endfunction

    // directed requests, then the random body
    initial begin
        clock_ms = 1000;
        queue_req(dir(OP_QUERY, 0, 0, 0, 0, 0));
        queue_req(dir(OP_SCAN, 0, 0, 0, 0, 0));
        queue_req(dir(OP_CANCEL, 3, 0, 0, 0, 0));
        queue_req(dir(OP_REFRESH, 15, 0, 0, 0, 0));
        queue_req(dir(OP_RESET, 5, 7, 0, 1, 0));
        queue_req(dir(t_opcode'(6), 0, 0, 0, 0, 0));
        queue_req(dir(t_opcode'(7), 15, '1, 1, 1, '1));
        // wrapping expiry at the top of the time range
        queue_req(dir(OP_ADD, 0, '1, 1, 0, 64'd5));
        for (int i = 1; i < NT; i++)
            queue_req(dir(OP_ADD, 0, 64'(50 + (i % 3) * 10), i[0], 0, 64'd100));
        queue_req(dir(OP_ADD, 0, 1, 0, 0, 0));  // table full
        queue_req(dir(OP_QUERY, 0, 0, 0, 0, 64'd101));
        queue_req(dir(OP_RESET, 2, 60, 0, 0, 64'd110)); // keep start, new period
        queue_req(dir(OP_RESET, 2, 1, 0, 0, 64'd110));  // keep start, shorter period
        queue_req(dir(OP_SCAN, 0, 0, 0, 0, '1));        // everything expired
        queue_req(dir(OP_QUERY, 0, 0, 0, 0, '1));
        for (int i = 0; i < N_RANDOM; i++) queue_req(rnd_req());
        feed_done = 1;
    end

    // request driver, changes at the falling edge
    int   drv_gap;
    int   sent_at;
    t_req cur;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
            drv_gap = 0;
        end else if (cmd_bus.valid && (n_req == sent_at)) begin
            // not yet accepted: hold the request
        end else begin
            if (cmd_bus.valid) drv_gap = gap_len();
            if (drv_gap > 0) begin
                drv_gap--;
                cmd_bus.valid <= 1'b0;
            end else if (req_q.size() > 0) begin
                cur = req_q.pop_front();
                sent_at = n_req;
                cmd_bus.valid     <= 1'b1;
                cmd_bus.opcode    <= cur.opcode;
                cmd_bus.slot      <= cur.slot;
                cmd_bus.period    <= cur.period;
                cmd_bus.recurring <= cur.recurring;
                cmd_bus.restart   <= cur.restart;
                cmd_bus.now       <= cur.now;
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    int stall;
    always @(negedge i_clk) begin
        if (stall > 0) begin
            stall--;
            res_bus.ready <= 1'b0;
        end else begin
            stall = gap_len();
            res_bus.ready <= (stall == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    // monitor at the rising edge
    t_req acc;
    t_res got;
    t_res want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                acc = {cmd_bus.opcode, cmd_bus.slot, cmd_bus.period, cmd_bus.recurring,
                       cmd_bus.restart, cmd_bus.now};
                n_req++;
                predict_timers(acc);
            end
            if (res_bus.valid && res_bus.ready) begin
                got = {res_bus.status, res_bus.timer_slot, res_bus.slot_valid,
                       res_bus.next_delay, res_bus.any_active, res_bus.notify_front,
                       res_bus.last};
                n_res++;
                if (due_q.size() == 0) report("unexpected result", got, got);
                else begin
                    want = due_q.pop_front();
                    if (got.status !== want.status) report("status", got, want);
                    if (got.timer_slot !== want.timer_slot) report("timer_slot", got, want);
                    if (got.slot_valid !== want.slot_valid) report("slot_valid", got, want);
                    if (got.next_delay !== want.next_delay) report("next_delay", got, want);
                    if (got.any_active !== want.any_active) report("any_active", got, want);
                    if (got.notify_front !== want.notify_front)
                        report("notify_front", got, want);
                    if (got.last !== want.last) report("last", got, want);
                end
            end
        end
    end

    // reset, then wait for the feed to drain
    initial begin
        n_err = 0; n_res = 0; n_req = 0; stall = 0; drv_gap = 0; sent_at = -1;
        latch = 0;
        for (int i = 0; i < NT; i++) begin
            act_m[i] = 0; rec_m[i] = 0; exp_t[i] = 0; per_t[i] = 0;
        end
        i_rst_n           = 1'b0;
        cmd_bus.valid     = 1'b0;
        cmd_bus.opcode    = OP_QUERY;
        cmd_bus.slot      = '0;
        cmd_bus.period    = '0;
        cmd_bus.recurring = 1'b0;
        cmd_bus.restart   = 1'b0;
        cmd_bus.now       = '0;
        res_bus.ready     = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (feed_done && req_q.size() == 0);
        @(posedge i_clk);
        while (cmd_bus.valid || due_q.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("covered %0d requests and %0d results over all six commands", n_req, n_res);
        $display("including full table, wrapping times, scans and back-pressure");
        if (n_err == 0 && due_q.size() == 0) begin
            $display("tb_ordered_timer_table passed");
        end else begin
            $display("tb_ordered_timer_table failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(12 * 6000000);
        $display("tb_ordered_timer_table failed");
        $finish;
    end

endmodule
